FILE: hdl/dmbf_pkg.sv
// ----------------------------------------------------------------------------
// dmbf_pkg
// Shared types and constants for the bit-image band formatter.
// ----------------------------------------------------------------------------
package dmbf_pkg;

  localparam int unsigned ColWidth   = 16;
  localparam int unsigned LimitWidth = 4;
  localparam int unsigned PixWidth   = 32;
  localparam int unsigned Rows       = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [0:0] {
    CFG_COLUMNS_PER_BAND = 1'b0,
    CFG_DARK_LIMIT       = 1'b1
  } dmbf_cfg_e;

  localparam logic [ColWidth-1:0]   ColumnsReset = 16'd640;
  localparam logic [LimitWidth-1:0] LimitReset   = 4'd6;

  localparam logic [7:0] ChrEsc  = 8'h1B;
  localparam logic [7:0] ChrStar = 8'h2A;
  localparam logic [7:0] ChrOne  = 8'h31;
  localparam logic [7:0] ChrMode = 8'h04;
  localparam logic [7:0] ChrNl   = 8'h0A;
  localparam logic [7:0] ChrFf   = 8'h0C;

  typedef struct packed {
    logic                hdr;
    logic                eob;
    logic                ff;
    logic [7:0]          pins;
    logic [ColWidth-1:0] width;
  } dmbf_entry_t;

endpackage

FILE: hdl/dmbf_front.sv
// ----------------------------------------------------------------------------
// dmbf_front
// Holds configuration and band position; turns each column into a work entry.
// ----------------------------------------------------------------------------
module dmbf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_addr,
  input  logic [dmbf_pkg::ColWidth-1:0]     cfg_wdata,
  input  logic                              col_valid,
  output logic                              col_ready,
  input  logic [dmbf_pkg::PixWidth-1:0]     col_pixels,
  input  logic                              col_final,
  input  logic                              q_full,
  output logic                              q_push,
  output dmbf_pkg::dmbf_entry_t             q_entry
);
  import dmbf_pkg::*;

  logic [ColWidth-1:0]   columns_r;
  logic [LimitWidth-1:0] limit_r;
  logic [ColWidth-1:0]   pos_r;
  logic [ColWidth-1:0]   pos_nxt;
  logic [ColWidth-1:0]   width_eff;
  logic                  eob;
  logic [7:0]            pins;

  assign col_ready = !q_full;
  assign q_push    = col_valid && !q_full;
  assign width_eff = (columns_r == '0) ? ColWidth'(1) : columns_r;
  assign eob       = ({1'b0, pos_r} + 17'd1) >= {1'b0, width_eff};
  assign pos_nxt   = eob ? '0 : pos_r + ColWidth'(1);

  always_comb begin
    pins = '0;
    for (int row = 0; row < Rows; row++) begin
      pins[Rows-1-row] = col_pixels[PixWidth-4-4*row +: 4] >= limit_r;
    end
  end

  assign q_entry.hdr   = (pos_r == '0);
  assign q_entry.eob   = eob;
  assign q_entry.ff    = eob && col_final;
  assign q_entry.pins  = pins;
  assign q_entry.width = width_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= ColumnsReset;
      limit_r   <= LimitReset;
      pos_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (dmbf_cfg_e'(cfg_addr))
          CFG_COLUMNS_PER_BAND: columns_r <= cfg_wdata;
          CFG_DARK_LIMIT:       limit_r   <= cfg_wdata[LimitWidth-1:0];
          default:              ;
        endcase
      end
      if (q_push) begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

FILE: hdl/dmbf_queue.sv
// ----------------------------------------------------------------------------
// dmbf_queue
// Short FIFO of work entries between the front and back parts.
// ----------------------------------------------------------------------------
module dmbf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dmbf_pkg::dmbf_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output dmbf_pkg::dmbf_entry_t head
);
  import dmbf_pkg::*;

  dmbf_entry_t          mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r;
  logic [QueuePtrW-1:0] rd_ptr_r;
  logic [QueueCntW-1:0] count_r;

  assign full  = (count_r == QueueCntW'(QueueDepth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QueuePtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QueueCntW'(1);
        2'b01:   count_r <= count_r - QueueCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/dmbf_back.sv
// ----------------------------------------------------------------------------
// dmbf_back
// Byte sequencer: band-start header, pin byte, band-end newline and form feed.
// ----------------------------------------------------------------------------
module dmbf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  dmbf_pkg::dmbf_entry_t q_head,
  output logic                  q_pop,
  output logic                  byte_valid,
  input  logic                  byte_ready,
  output logic [7:0]            byte_data,
  output logic                  byte_last
);
  import dmbf_pkg::*;

  localparam logic [3:0] StepEsc1   = 4'd0;
  localparam logic [3:0] StepOne    = 4'd1;
  localparam logic [3:0] StepEsc2   = 4'd2;
  localparam logic [3:0] StepStar   = 4'd3;
  localparam logic [3:0] StepMode   = 4'd4;
  localparam logic [3:0] StepWidthL = 4'd5;
  localparam logic [3:0] StepWidthH = 4'd6;
  localparam logic [3:0] StepPins   = 4'd7;
  localparam logic [3:0] StepNl     = 4'd8;
  localparam logic [3:0] StepFf     = 4'd9;

  logic       busy_r;
  logic [3:0] step_r;
  logic [3:0] cur_step;
  logic [3:0] last_step;
  logic       is_last;
  logic       load;
  logic [7:0] cur_byte;
  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  assign cur_step  = busy_r ? step_r : (q_head.hdr ? StepEsc1 : StepPins);
  assign last_step = !q_head.eob ? StepPins : (q_head.ff ? StepFf : StepNl);
  assign is_last   = (cur_step == last_step);
  assign load      = !q_empty && (!valid_r || byte_ready);
  assign q_pop     = load && is_last;

  always_comb begin
    unique case (cur_step)
      StepEsc1:   cur_byte = ChrEsc;
      StepOne:    cur_byte = ChrOne;
      StepEsc2:   cur_byte = ChrEsc;
      StepStar:   cur_byte = ChrStar;
      StepMode:   cur_byte = ChrMode;
      StepWidthL: cur_byte = q_head.width[7:0];
      StepWidthH: cur_byte = q_head.width[15:8];
      StepPins:   cur_byte = q_head.pins;
      StepNl:     cur_byte = ChrNl;
      StepFf:     cur_byte = ChrFf;
      default:    cur_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        busy_r  <= !is_last;
        step_r  <= cur_step + 4'd1;
      end else if (byte_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= cur_byte;
      last_r <= is_last;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;
  assign byte_last  = last_r;

endmodule

FILE: hdl/dot_matrix_bit_image_band_formatter.sv
// ----------------------------------------------------------------------------
// dot_matrix_bit_image_band_formatter
// Turns 8-row pixel columns into bit-image printer bytes, band by band.
// ----------------------------------------------------------------------------
// The first byte of a column passes through the queue and the output byte register.
// Throughput: one output byte per cycle while out_tready is high and the queue is
// not empty; a column gives one byte when plain, two or three at a band end, eight
// to ten at a band start; a two-entry queue lets the input side run ahead.
// Synchronous active-low reset restores width 640, dark limit 6 and the
// start-of-band position.
// ----------------------------------------------------------------------------
module dot_matrix_bit_image_band_formatter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_addr,
  input  logic [dmbf_pkg::ColWidth-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // pixel_column[31:0]
  input  logic [0:0]                    in_tuser,   // final_band[0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // out_byte[7:0]
  output logic                          out_tlast
);
  import dmbf_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  dmbf_entry_t q_entry;
  dmbf_entry_t q_head;

  dmbf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .col_valid  (in_tvalid),
    .col_ready  (in_tready),
    .col_pixels (in_tdata),
    .col_final  (in_tuser[0]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  dmbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  dmbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .byte_valid (out_tvalid),
    .byte_ready (out_tready),
    .byte_data  (out_tdata),
    .byte_last  (out_tlast)
  );

endmodule
